/* sv/assert_macros.svh */
// Assertion macros used by the checker file of this project.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define TTE_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TTE_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/tte_pkg.sv */
// Shared types, constants and tables for the timestamp text to epoch block.
// No dependencies.
`default_nettype none

package tte_pkg;

    // Number parsing
    localparam int MAX_DIGITS = 9;
    localparam int ACC_W      = 30;          // holds 10**MAX_DIGITS - 1
    localparam int FIELD_W    = ACC_W + 1;   // signed field value
    localparam int DCNT_W     = $clog2(MAX_DIGITS + 1);
    localparam int FR_W       = 3;           // up to six completed numbers
    localparam int NUM_FIELDS = 6;
    localparam int FIDX_W     = $clog2(NUM_FIELDS);

    typedef logic signed [FIELD_W-1:0] field_t;

    // Format positions: even codes are numbers, odd codes are literals.
    localparam logic [3:0] PHASE_YEAR   = 4'd0;
    localparam logic [3:0] PHASE_DASH1  = 4'd1;
    localparam logic [3:0] PHASE_MONTH  = 4'd2;
    localparam logic [3:0] PHASE_DASH2  = 4'd3;
    localparam logic [3:0] PHASE_DAY    = 4'd4;
    localparam logic [3:0] PHASE_SEP    = 4'd5;
    localparam logic [3:0] PHASE_HOUR   = 4'd6;
    localparam logic [3:0] PHASE_COLON1 = 4'd7;
    localparam logic [3:0] PHASE_MIN    = 4'd8;
    localparam logic [3:0] PHASE_COLON2 = 4'd9;
    localparam logic [3:0] PHASE_SEC    = 4'd10;
    localparam logic [3:0] PHASE_DONE   = 4'd11;

    localparam logic [1:0] SUB_SKIP   = 2'd0;
    localparam logic [1:0] SUB_SIGN   = 2'd1;
    localparam logic [1:0] SUB_DIGITS = 2'd2;

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_0     = 8'd48;
    localparam logic [7:0] CH_9     = 8'd57;
    localparam logic [7:0] CH_COLON = 8'd58;

    // Queue between parser and date unit
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Date arithmetic
    localparam int DIV_BITS     = FIELD_W;
    localparam int DIVISOR      = 400;
    localparam int REM_W        = 9;
    localparam int ERA_W        = 23;
    localparam int QUO_W        = ERA_W - 1;
    // 400 = 16 * 25: the low four bits are dropped, then a multiply by
    // ceil(2**33 / 25) and a shift by 33 divides by 25 exactly.
    localparam int DIV_SHIFT    = 4;
    localparam int RECIP_25     = 343597384;
    localparam int RECIP_W      = 29;
    localparam int RECIP_SHIFT  = 33;
    localparam int RPROD_W      = DIV_BITS - DIV_SHIFT + RECIP_W;
    localparam int DOE_W        = 18;
    localparam int DAYS_W       = 41;
    localparam int ERA_DAYS     = 146097;
    localparam int EPOCH_SHIFT  = 719468;
    localparam int SEC_PER_DAY  = 86400;
    localparam int SEC_PER_HOUR = 3600;
    localparam int SEC_PER_MIN  = 60;
    localparam int SPLIT_W      = 20;
    localparam int PLO_W        = 37;
    localparam int PHI_W        = 38;
    localparam int HT_W         = 43;
    localparam int MS_W         = 38;
    localparam int EPOCH_W      = 57;
    localparam int YDAY_W       = 9;

    typedef struct packed {
        logic        vld;
        field_t      year;
        logic [3:0]  month;
        logic [4:0]  day;
        field_t      hour;
        field_t      minute;
        field_t      second;
    } rec_t;

    // Days from March 1 to the first of month index mp (March is zero).
    function automatic logic [8:0] march_cum(input logic [3:0] mp);
        logic [8:0] v;
        case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // Days before month m in a common year.
    function automatic logic [8:0] jan_cum(input logic [3:0] m);
        logic [8:0] v;
        case (m)
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // Field value from magnitude and sign.
    function automatic field_t signed_val(input logic neg, input logic [ACC_W-1:0] acc);
        field_t mag;
        mag = field_t'({1'b0, acc});
        return neg ? -mag : mag;
    endfunction

endpackage

`default_nettype wire

/* sv/tte_front.sv */
// Character parser: follows the "Y-M-D h:m:s" format one item per cycle while
// the queue has room; hands a finished record to the queue. Depends on tte_pkg.
`default_nettype none

module tte_front import tte_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_ch,
    input  wire logic       s_char_present,
    input  wire logic       s_last,
    input  wire logic       q_full,
    output logic            push,
    output rec_t            push_rec
);

    logic [3:0]        phase_reg, phase_next;
    logic [1:0]        sub_reg, sub_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic              neg_reg, neg_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic              stop_reg, stop_next;
    logic              ovf_reg, ovf_next;
    logic [FR_W-1:0]   fr_reg, fr_next;
    field_t            fields_reg [NUM_FIELDS];
    field_t            fields_next [NUM_FIELDS];
    field_t            fin_fields [NUM_FIELDS];
    logic [FR_W-1:0]   fin_fr;
    logic              is_dig, is_sp, handled, accept;
    logic [ACC_W-1:0]  dval;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign is_dig  = s_ch inside {[CH_0:CH_9]};
    assign is_sp   = s_ch inside {CH_SPACE, [CH_TAB:CH_CR]};
    assign dval    = ACC_W'(s_ch[3:0]);

    always_comb begin
        phase_next  = phase_reg;
        sub_next    = sub_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        dcnt_next   = dcnt_reg;
        stop_next   = stop_reg;
        ovf_next    = ovf_reg;
        fr_next     = fr_reg;
        fields_next = fields_reg;
        handled     = 1'b0;

        if (accept && s_char_present && !stop_reg && phase_reg < PHASE_DONE) begin
            // Inside a number: take a digit, or complete the number and let the
            // same character fall through to the next format element.
            if (!phase_reg[0] && sub_reg == SUB_DIGITS) begin
                if (is_dig) begin
                    handled = 1'b1;
                    if (dcnt_reg >= DCNT_W'(MAX_DIGITS)) begin
                        ovf_next  = 1'b1;
                        stop_next = 1'b1;
                    end else begin
                        acc_next  = (acc_reg << 3) + (acc_reg << 1) + dval;
                        dcnt_next = dcnt_reg + 1'b1;
                    end
                end else begin
                    fields_next[phase_reg[FIDX_W:1]] = signed_val(neg_reg, acc_reg);
                    fr_next    = fr_reg + 1'b1;
                    phase_next = phase_reg + 1'b1;
                    sub_next   = SUB_SKIP;
                    acc_next   = '0;
                    neg_next   = 1'b0;
                    dcnt_next  = '0;
                end
            end

            if (!handled && phase_next[0] && phase_next < PHASE_DONE) begin
                if (phase_next == PHASE_SEP) begin
                    // The space of the format eats any run of whitespace.
                    if (is_sp) begin
                        handled = 1'b1;
                    end else begin
                        phase_next = PHASE_HOUR;
                    end
                end else begin
                    handled = 1'b1;
                    if (s_ch == ((phase_next <= PHASE_DASH2) ? CH_MINUS : CH_COLON)) begin
                        phase_next = phase_next + 1'b1;
                    end else begin
                        stop_next = 1'b1;
                    end
                end
            end

            if (!handled && !phase_next[0] && phase_next < PHASE_DONE) begin
                if (is_dig) begin
                    acc_next  = dval;
                    dcnt_next = DCNT_W'(1);
                    sub_next  = SUB_DIGITS;
                end else if (sub_next == SUB_SKIP && is_sp) begin
                    sub_next = SUB_SKIP;
                end else if (sub_next == SUB_SKIP && (s_ch == CH_PLUS || s_ch == CH_MINUS)) begin
                    neg_next = (s_ch == CH_MINUS);
                    sub_next = SUB_SIGN;
                end else begin
                    stop_next = 1'b1;
                end
            end
        end

        // A number still in its digits is completed by the end of the text.
        fin_fields = fields_next;
        fin_fr     = fr_next;
        if (!stop_next && phase_next < PHASE_DONE && !phase_next[0]
                && sub_next == SUB_DIGITS) begin
            fin_fields[phase_next[FIDX_W:1]] = signed_val(neg_next, acc_next);
            fin_fr = fr_next + 1'b1;
        end

        push_rec.vld    = !ovf_next && fin_fr >= FR_W'(3)
                          && fin_fields[1] >= field_t'(1) && fin_fields[1] <= field_t'(12)
                          && fin_fields[2] >= field_t'(1) && fin_fields[2] <= field_t'(31);
        push_rec.year   = fin_fields[0];
        push_rec.month  = fin_fields[1][3:0];
        push_rec.day    = fin_fields[2][4:0];
        push_rec.hour   = fin_fields[3];
        push_rec.minute = fin_fields[4];
        push_rec.second = fin_fields[5];
        push            = accept && s_last;

        if (accept && s_last) begin
            phase_next = PHASE_YEAR;
            sub_next   = SUB_SKIP;
            acc_next   = '0;
            neg_next   = 1'b0;
            dcnt_next  = '0;
            stop_next  = 1'b0;
            ovf_next   = 1'b0;
            fr_next    = '0;
            for (int i = 0; i < NUM_FIELDS; i++) begin
                fields_next[i] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PHASE_YEAR;
            sub_reg   <= SUB_SKIP;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            dcnt_reg  <= '0;
            stop_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            fr_reg    <= '0;
            for (int i = 0; i < NUM_FIELDS; i++) begin
                fields_reg[i] <= '0;
            end
        end else begin
            phase_reg  <= phase_next;
            sub_reg    <= sub_next;
            acc_reg    <= acc_next;
            neg_reg    <= neg_next;
            dcnt_reg   <= dcnt_next;
            stop_reg   <= stop_next;
            ovf_reg    <= ovf_next;
            fr_reg     <= fr_next;
            fields_reg <= fields_next;
        end
    end

endmodule

`default_nettype wire

/* sv/tte_queue.sv */
// Short record queue between the parser and the date unit.
// Depends on tte_pkg.
`default_nettype none

module tte_queue import tte_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  rec_t      push_rec,
    output logic      q_full,
    output logic      q_valid,
    input  wire logic pop,
    output rec_t      q_rec
);

    rec_t              entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign q_full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_rec   = entries[rd_ptr_reg];
    assign do_push = push && !q_full;
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

/* sv/tte_back.sv */
// Date unit: turns a parsed record into epoch seconds, hour and day of year,
// with a reciprocal-multiply floor division by 400 and a short multiply sequence.
// Depends on tte_pkg.
`default_nettype none

module tte_back import tte_pkg::*; (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      q_valid,
    input  rec_t                           q_rec,
    output logic                           pop,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_valid_res,
    output logic signed [EPOCH_W-1:0]      m_epoch_seconds,
    output logic signed [FIELD_W-1:0]      m_hour_value,
    output logic [YDAY_W-1:0]              m_day_of_year
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_REM  = 3'd2;
    localparam logic [2:0] ST_CAL0 = 3'd3;
    localparam logic [2:0] ST_CAL1 = 3'd4;
    localparam logic [2:0] ST_MUL  = 3'd5;
    localparam logic [2:0] ST_SUM  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0]                state_reg, state_next;
    logic                      vld_reg, vld_next;
    logic [3:0]                m_reg, m_next;
    logic [4:0]                d_reg, d_next;
    field_t                    h_reg, h_next;
    field_t                    mi_reg, mi_next;
    field_t                    s_reg, s_next;
    logic                      neg_reg, neg_next;
    logic [DIV_BITS-1:0]       num_reg, num_next;
    logic [QUO_W-1:0]          quo_reg, quo_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic signed [DAYS_W-1:0]  era_days_reg, era_days_next;
    logic [DOE_W-1:0]          doe_reg, doe_next;
    logic [YDAY_W-1:0]         yday_reg, yday_next;
    logic signed [DAYS_W-1:0]  days_reg, days_next;
    logic [PLO_W-1:0]          plo_reg, plo_next;
    logic signed [PHI_W-1:0]   phi_reg, phi_next;
    logic signed [HT_W-1:0]    ht_reg, ht_next;
    logic signed [MS_W-1:0]    ms_reg, ms_next;
    logic [EPOCH_W-1:0]        dsec_reg, dsec_next;
    logic [EPOCH_W-1:0]        tsec_reg, tsec_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      res_reg, res_next;
    logic [EPOCH_W-1:0]        epoch_reg, epoch_next;
    field_t                    hour_reg, hour_next;
    logic [YDAY_W-1:0]         oyday_reg, oyday_next;

    logic signed [FIELD_W:0]   ym1;
    logic [FIELD_W:0]          mag;
    logic [RPROD_W-1:0]        prod;
    logic signed [ERA_W-1:0]   era;
    logic [REM_W-1:0]          yoe;
    logic [1:0]                c100;
    logic                      leap;
    logic [3:0]                mp;

    assign m_valid         = out_valid_reg;
    assign m_valid_res     = res_reg;
    assign m_epoch_seconds = $signed(epoch_reg);
    assign m_hour_value    = hour_reg;
    assign m_day_of_year   = oyday_reg;

    // Year shifted to start in March, and its magnitude prepared for a
    // division that rounds toward minus infinity.
    assign ym1 = (FIELD_W + 1)'(q_rec.year)
                 - ((q_rec.month <= 4'd2) ? (FIELD_W + 1)'(1) : '0);
    assign mag = ym1[FIELD_W] ? ((FIELD_W + 1)'(-ym1) + (FIELD_W + 1)'(DIVISOR - 1))
                              : ym1;

    // Magnitude divided by 16, times the reciprocal of 25.
    assign prod = RPROD_W'(num_reg[DIV_BITS-1:DIV_SHIFT]) * RPROD_W'(RECIP_25);

    // Quotient and remainder give era and year of era.
    assign era  = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign yoe  = neg_reg ? REM_W'(DIVISOR - 1) - rem_reg : rem_reg;
    assign c100 = (yoe >= REM_W'(300)) ? 2'd3 :
                  (yoe >= REM_W'(200)) ? 2'd2 :
                  (yoe >= REM_W'(100)) ? 2'd1 : 2'd0;
    assign leap = (yoe[1:0] == 2'b00) && !(yoe inside {REM_W'(100), REM_W'(200), REM_W'(300)});
    assign mp   = (m_reg > 4'd2) ? m_reg - 4'd3 : m_reg + 4'd9;

    always_comb begin
        state_next     = state_reg;
        vld_next       = vld_reg;
        m_next         = m_reg;
        d_next         = d_reg;
        h_next         = h_reg;
        mi_next        = mi_reg;
        s_next         = s_reg;
        neg_next       = neg_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        era_days_next  = era_days_reg;
        doe_next       = doe_reg;
        yday_next      = yday_reg;
        days_next      = days_reg;
        plo_next       = plo_reg;
        phi_next       = phi_reg;
        ht_next        = ht_reg;
        ms_next        = ms_reg;
        dsec_next      = dsec_reg;
        tsec_next      = tsec_reg;
        res_next       = res_reg;
        epoch_next     = epoch_reg;
        hour_next      = hour_reg;
        oyday_next     = oyday_reg;
        pop            = 1'b0;
        out_valid_next = out_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    pop        = 1'b1;
                    vld_next   = q_rec.vld;
                    m_next     = q_rec.month;
                    d_next     = q_rec.day;
                    h_next     = q_rec.hour;
                    mi_next    = q_rec.minute;
                    s_next     = q_rec.second;
                    neg_next   = ym1[FIELD_W];
                    num_next   = mag[DIV_BITS-1:0];
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                quo_next   = prod[RECIP_SHIFT +: QUO_W];
                state_next = ST_REM;
            end
            ST_REM: begin
                rem_next   = REM_W'(num_reg - DIV_BITS'(quo_reg) * DIV_BITS'(DIVISOR));
                state_next = ST_CAL0;
            end
            ST_CAL0: begin
                era_days_next = DAYS_W'(era) * $signed(DAYS_W'(ERA_DAYS));
                doe_next      = DOE_W'(yoe) * DOE_W'(365) + DOE_W'(yoe[REM_W-1:2])
                                - DOE_W'(c100) + DOE_W'(march_cum(mp))
                                + DOE_W'(d_reg) - DOE_W'(1);
                yday_next     = jan_cum(m_reg) + YDAY_W'(leap && m_reg > 4'd2)
                                + YDAY_W'(d_reg);
                state_next    = ST_CAL1;
            end
            ST_CAL1: begin
                days_next  = era_days_reg + $signed({{(DAYS_W - DOE_W){1'b0}}, doe_reg})
                             - $signed(DAYS_W'(EPOCH_SHIFT));
                state_next = ST_MUL;
            end
            ST_MUL: begin
                // The day count is split so that each product stays narrow.
                plo_next   = PLO_W'(days_reg[SPLIT_W-1:0]) * PLO_W'(SEC_PER_DAY);
                phi_next   = PHI_W'($signed(days_reg[DAYS_W-1:SPLIT_W]))
                             * $signed(PHI_W'(SEC_PER_DAY));
                ht_next    = HT_W'(h_reg) * $signed(HT_W'(SEC_PER_HOUR));
                ms_next    = MS_W'(mi_reg) * $signed(MS_W'(SEC_PER_MIN)) + MS_W'(s_reg);
                state_next = ST_SUM;
            end
            ST_SUM: begin
                dsec_next  = EPOCH_W'({phi_reg, {SPLIT_W{1'b0}}}) + EPOCH_W'(plo_reg);
                tsec_next  = EPOCH_W'(ht_reg) + EPOCH_W'(ms_reg);
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    res_next       = vld_reg;
                    epoch_next     = vld_reg ? dsec_reg + tsec_reg : '0;
                    hour_next      = vld_reg ? h_reg : '0;
                    oyday_next     = vld_reg ? yday_reg : '0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        vld_reg      <= vld_next;
        m_reg        <= m_next;
        d_reg        <= d_next;
        h_reg        <= h_next;
        mi_reg       <= mi_next;
        s_reg        <= s_next;
        neg_reg      <= neg_next;
        num_reg      <= num_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        era_days_reg <= era_days_next;
        doe_reg      <= doe_next;
        yday_reg     <= yday_next;
        days_reg     <= days_next;
        plo_reg      <= plo_next;
        phi_reg      <= phi_next;
        ht_reg       <= ht_next;
        ms_reg       <= ms_next;
        dsec_reg     <= dsec_next;
        tsec_reg     <= tsec_next;
        res_reg      <= res_next;
        epoch_reg    <= epoch_next;
        hour_reg     <= hour_next;
        oyday_reg    <= oyday_next;
    end

endmodule

`default_nettype wire

/* sv/timestamp_text_to_epoch.sv */
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_ch[7:0], s_char_present, s_last
// m_        out        m_valid/m_ready    m_valid_res, m_epoch_seconds[56:0],
//                                         m_hour_value[30:0], m_day_of_year[8:0]
//
// The parser takes one character item per cycle while the record queue has room.
// From leaving the queue to a loaded result, each timestamp passes through the date
// unit states in order: ST_IDLE takes the record, ST_DIV and ST_REM divide the year
// by 400 by a reciprocal multiply, ST_CAL0 and ST_CAL1 form the day count, ST_MUL
// the second multiplies, ST_SUM the sums and ST_OUT the output load.
// Reset (aresetn low, synchronous) clears parser, queue and date unit; nothing
// else needs clearing. A stalled result holds in the output register while the
// parser keeps taking items until the queue is full.
// Top level of the timestamp text to epoch block. Depends on tte_pkg,
// tte_front, tte_queue and tte_back.
`default_nettype none

module timestamp_text_to_epoch import tte_pkg::*; (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [7:0]                 s_ch,
    input  wire logic                       s_char_present,
    input  wire logic                       s_last,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic                            m_valid_res,
    output logic signed [EPOCH_W-1:0]       m_epoch_seconds,
    output logic signed [FIELD_W-1:0]       m_hour_value,
    output logic [YDAY_W-1:0]               m_day_of_year
);

    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    rec_t push_rec;
    rec_t q_rec;

    tte_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_ch           (s_ch),
        .s_char_present (s_char_present),
        .s_last         (s_last),
        .q_full         (q_full),
        .push           (push),
        .push_rec       (push_rec)
    );

    tte_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .q_full   (q_full),
        .q_valid  (q_valid),
        .pop      (pop),
        .q_rec    (q_rec)
    );

    tte_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_rec           (q_rec),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_valid_res     (m_valid_res),
        .m_epoch_seconds (m_epoch_seconds),
        .m_hour_value    (m_hour_value),
        .m_day_of_year   (m_day_of_year)
    );

endmodule

`default_nettype wire

/* sv/tte_checker.sv */
// Port-level checks for timestamp_text_to_epoch, attached by bind.
// Depends on tte_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tte_checker import tte_pkg::*; (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_valid,
    input wire logic                       s_ready,
    input wire logic [7:0]                 s_ch,
    input wire logic                       s_char_present,
    input wire logic                       s_last,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire logic                       m_valid_res,
    input wire logic signed [EPOCH_W-1:0]  m_epoch_seconds,
    input wire logic signed [FIELD_W-1:0]  m_hour_value,
    input wire logic [YDAY_W-1:0]          m_day_of_year
);

    // A result that is not taken stays with its epoch seconds and day of year unchanged.
    `TTE_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_epoch_seconds) && $stable(m_day_of_year), "stalled result changed")

    // An invalid result carries zeros in every numeric field.
    `TTE_ASSERT(a_invalid_zero, aclk, aresetn, m_valid && !m_valid_res |-> m_epoch_seconds == '0 && m_hour_value == '0 && m_day_of_year == '0, "invalid result is not zero")

    // A valid result has a day of year inside a leap year.
    `TTE_ASSERT(a_yday_range, aclk, aresetn, m_valid && m_valid_res |-> m_day_of_year >= YDAY_W'(1) && m_day_of_year <= YDAY_W'(366), "day of year out of range")

    // Reset leaves no result pending.
    `TTE_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result pending after reset")

endmodule

bind timestamp_text_to_epoch tte_checker u_tte_checker (.*);

`default_nettype wire

/* tb/sv/timestamp_epoch_checker.sv */
// Result checker for timestamp_text_to_epoch: follows the character items on the input
// channel, predicts the result of every finished text and compares each output item.
// Depends on tte_pkg.
module timestamp_epoch_checker import tte_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic [7:0]                s_ch,
    input  logic                      s_char_present,
    input  logic                      s_last,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic                      m_valid_res,
    input  logic signed [EPOCH_W-1:0] m_epoch_seconds,
    input  logic signed [FIELD_W-1:0] m_hour_value,
    input  logic [YDAY_W-1:0]         m_day_of_year,
    output int                        mismatch_count,
    output int                        pending_stamps
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint DAYS_PER_ERA    = 146097;
    localparam longint UNIX_DAY_OFFSET = 719468;
    localparam longint SECS_PER_DAY    = 86400;
    localparam longint SECS_PER_HOUR   = 3600;
    localparam longint SECS_PER_MIN    = 60;

    typedef struct packed {
        logic               ok;
        logic [EPOCH_W-1:0] epoch;
        logic [FIELD_W-1:0] hour;
        logic [YDAY_W-1:0]  yday;
    } stamp_result_t;

    stamp_result_t expected_stamps[$];
    int errors_seen = 0;
    int waiting = 0;
    int results_seen = 0;

    assign mismatch_count = errors_seen;
    assign pending_stamps = waiting;

    // Parser state of the predictor.
    logic [3:0]  phase;
    logic [1:0]  num_state;
    int unsigned mag_acc;
    bit          mag_neg;
    int unsigned digits;
    int          fields[NUM_FIELDS];
    int unsigned fields_done;
    bit          halted;
    bit          too_long;

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic void clear_number();
        num_state = SUB_SKIP;
        mag_acc = 0;
        mag_neg = 1'b0;
        digits = 0;
    endfunction

    function automatic void clear_parse();
        phase = PHASE_YEAR;
        clear_number();
        foreach (fields[i]) fields[i] = 0;
        fields_done = 0;
        halted = 1'b0;
        too_long = 1'b0;
    endfunction

    function automatic void commit_number();
        fields[phase >> 1] = mag_neg ? -int'(mag_acc) : int'(mag_acc);
        fields_done++;
        phase++;
        clear_number();
    endfunction

    // A character that ends a number is handed on to the next format element,
    // hence the loop.
    function automatic void parse_char(input logic [7:0] c);
        bit again;
        again = 1'b1;
        while (again && !halted && phase < PHASE_DONE) begin
            again = 1'b0;
            if (!phase[0]) begin
                if (num_state == SUB_DIGITS) begin
                    if (!is_digit(c)) begin
                        commit_number();
                        again = 1'b1;
                    end else if (digits >= MAX_DIGITS) begin
                        too_long = 1'b1;
                        halted = 1'b1;
                    end else begin
                        mag_acc = mag_acc * 10 + (c - CH_0);
                        digits++;
                    end
                end else if (is_digit(c)) begin
                    mag_acc = c - CH_0;
                    digits = 1;
                    num_state = SUB_DIGITS;
                end else if (num_state == SUB_SKIP && is_space(c)) begin
                end else if (num_state == SUB_SKIP && (c == CH_PLUS || c == CH_MINUS)) begin
                    mag_neg = (c == CH_MINUS);
                    num_state = SUB_SIGN;
                end else begin
                    halted = 1'b1;
                end
            end else if (phase == PHASE_SEP) begin
                if (!is_space(c)) begin
                    phase = PHASE_HOUR;
                    again = 1'b1;
                end
            end else if (c == ((phase <= PHASE_DASH2) ? CH_MINUS : CH_COLON)) begin
                phase++;
            end else begin
                halted = 1'b1;
            end
        end
    endfunction

    // Days since 1970-01-01 in the proleptic Gregorian calendar; the year is
    // counted from March so that the leap day comes last.
    function automatic longint civil_day_count(input longint y, input longint mo,
                                               input longint d);
        longint era, yoe, mp, doy, doe;
        if (mo <= 2) begin
            y = y - 1;
        end
        era = (y >= 0 ? y : y - 399) / 400;
        yoe = y - era * 400;
        mp = (mo > 2) ? mo - 3 : mo + 9;
        doy = (153 * mp + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * DAYS_PER_ERA + doe - UNIX_DAY_OFFSET;
    endfunction

    function automatic void close_stamp();
        stamp_result_t r;
        longint y, mo, d, days;
        if (!halted && phase < PHASE_DONE && !phase[0] && num_state == SUB_DIGITS) begin
            commit_number();
        end
        y = fields[0];
        mo = fields[1];
        d = fields[2];
        r = '0;
        r.ok = !too_long && fields_done >= 3 && mo >= 1 && mo <= 12 && d >= 1 && d <= 31;
        if (r.ok) begin
            days = civil_day_count(y, mo, d);
            r.epoch = EPOCH_W'(days * SECS_PER_DAY + longint'(fields[3]) * SECS_PER_HOUR
                               + longint'(fields[4]) * SECS_PER_MIN + longint'(fields[5]));
            r.hour = FIELD_W'(fields[3]);
            r.yday = YDAY_W'(days - civil_day_count(y, 1, 1) + 1);
        end
        expected_stamps.push_back(r);
        clear_parse();
    endfunction

    task automatic report_mismatch(input string msg);
        errors_seen++;
        $display("%0t ns result %0d: %s", $realtime, results_seen, msg);
    endtask

    always @(posedge aclk) begin : watch
        stamp_result_t want;
        if (!aresetn) begin
            clear_parse();
            expected_stamps.delete();
        end else begin
            if (s_valid && s_ready) begin
                if (s_char_present) begin
                    parse_char(s_ch);
                end
                if (s_last) begin
                    close_stamp();
                end
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_stamps.size() == 0) begin
                    report_mismatch("result item with no text waiting for one");
                end else begin
                    want = expected_stamps.pop_front();
                    if (m_valid_res !== want.ok) begin
                        report_mismatch($sformatf("valid_res %0b, expected %0b",
                                                  m_valid_res, want.ok));
                    end
                    if (m_epoch_seconds !== want.epoch) begin
                        report_mismatch($sformatf("epoch_seconds %0d, expected %0d",
                                                  m_epoch_seconds, $signed(want.epoch)));
                    end
                    if (m_hour_value !== want.hour) begin
                        report_mismatch($sformatf("hour_value %0d, expected %0d",
                                                  m_hour_value, $signed(want.hour)));
                    end
                    if (m_day_of_year !== want.yday) begin
                        report_mismatch($sformatf("day_of_year %0d, expected %0d",
                                                  m_day_of_year, want.yday));
                    end
                end
            end
        end
        waiting <= expected_stamps.size();
    end

endmodule

/* tb/sv/timestamp_text_to_epoch_tb.sv */
// Testbench top for timestamp_text_to_epoch: feeds directed and random timestamp texts
// one character item at a time and gives the verdict. Depends on tte_pkg, the block
// and timestamp_epoch_checker.
module timestamp_text_to_epoch_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tte_pkg::*;

    localparam int ITEM_TARGET     = 1350;
    localparam int CALM_AFTER      = 1150;
    localparam int HOLD_AT         = 400;
    localparam int PAUSE_AT        = 800;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 80;
    localparam int LIMIT_CYCLES    = 500000;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_TOP   = 8'hFF;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [7:0]                s_ch;
    logic                      s_char_present;
    logic                      s_last;
    logic                      m_valid;
    logic                      m_ready;
    logic                      m_valid_res;
    logic signed [EPOCH_W-1:0] m_epoch_seconds;
    logic signed [FIELD_W-1:0] m_hour_value;
    logic [YDAY_W-1:0]         m_day_of_year;

    int mismatch_count;
    int pending_stamps;

    bit gaps_on = 1'b1;
    bit hold_off_req = 1'b0;
    int chars_sent = 0;
    logic [7:0] stamp_chars[$];

    timestamp_text_to_epoch i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_ch            (s_ch),
        .s_char_present  (s_char_present),
        .s_last          (s_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_valid_res     (m_valid_res),
        .m_epoch_seconds (m_epoch_seconds),
        .m_hour_value    (m_hour_value),
        .m_day_of_year   (m_day_of_year)
    );

    timestamp_epoch_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_ch            (s_ch),
        .s_char_present  (s_char_present),
        .s_last          (s_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_valid_res     (m_valid_res),
        .m_epoch_seconds (m_epoch_seconds),
        .m_hour_value    (m_hour_value),
        .m_day_of_year   (m_day_of_year),
        .mismatch_count  (mismatch_count),
        .pending_stamps  (pending_stamps)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void put_str(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            stamp_chars.push_back(txt[i]);
        end
    endfunction

    function automatic logic [7:0] any_space();
        int pick;
        pick = $urandom_range(0, 5);
        return (pick == 5) ? CH_SPACE : CH_TAB + 8'(pick);
    endfunction

    // Mostly plain numbers; now and then leading blanks, a plus sign, leading
    // zeros, and rarely more digits than the parser accepts.
    function automatic void put_num(input bit neg, input int unsigned mag);
        string digits_txt;
        int zeros;
        digits_txt = $sformatf("%0d", mag);
        zeros = 0;
        if ($urandom_range(0, 39) == 0) begin
            zeros = MAX_DIGITS + 1 - digits_txt.len() + $urandom_range(0, 1);
        end else if (digits_txt.len() < MAX_DIGITS && $urandom_range(0, 4) == 0) begin
            zeros = $urandom_range(1, MAX_DIGITS - digits_txt.len());
        end
        if ($urandom_range(0, 7) == 0) begin
            stamp_chars.push_back(any_space());
        end
        if (neg) begin
            stamp_chars.push_back(CH_MINUS);
        end else if ($urandom_range(0, 9) == 0) begin
            stamp_chars.push_back(CH_PLUS);
        end
        repeat (zeros) stamp_chars.push_back(CH_0);
        put_str(digits_txt);
    endfunction

    function automatic int unsigned pick_mag(input int unsigned typical_max);
        if ($urandom_range(0, 11) == 0) begin
            return $urandom_range(0, 999999999);
        end
        return $urandom_range(0, typical_max);
    endfunction

    function automatic void build_random_stamp();
        int unsigned mag[NUM_FIELDS];
        bit neg[NUM_FIELDS];
        int nfields;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: mag[0] = $urandom_range(0, 3000);
            6, 7:             mag[0] = $urandom_range(0, 999999999);
            8:                mag[0] = $urandom_range(0, 99);
            default:          mag[0] = $urandom_range(0, 99999);
        endcase
        mag[1] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
        mag[2] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 31);
        mag[3] = pick_mag(23);
        mag[4] = pick_mag(59);
        mag[5] = pick_mag(59);
        for (int f = 0; f < NUM_FIELDS; f++) begin
            neg[f] = ($urandom_range(0, (f == 1 || f == 2) ? 29 : 9) == 0);
        end
        nfields = ($urandom_range(0, 7) != 0) ? NUM_FIELDS : $urandom_range(1, NUM_FIELDS - 1);
        for (int f = 0; f < nfields; f++) begin
            if (f == 1 || f == 2) begin
                stamp_chars.push_back(CH_MINUS);
            end else if (f == 3) begin
                repeat (($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : 1) begin
                    stamp_chars.push_back(any_space());
                end
            end else if (f > 3) begin
                stamp_chars.push_back(CH_COLON);
            end
            put_num(neg[f], mag[f]);
        end
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3)) stamp_chars.push_back(8'($urandom_range(0, 255)));
        end
        if (stamp_chars.size() > 0 && $urandom_range(0, 9) == 0) begin
            stamp_chars[$urandom_range(0, stamp_chars.size() - 1)] = 8'($urandom_range(0, 255));
        end
    endfunction

    function automatic void build_noise_stamp();
        repeat ($urandom_range(0, 12)) begin
            case ($urandom_range(0, 4))
                0:       stamp_chars.push_back(8'($urandom_range(0, 255)));
                1:       stamp_chars.push_back(CH_0 + 8'($urandom_range(0, 9)));
                2:       stamp_chars.push_back(CH_MINUS);
                3:       stamp_chars.push_back(CH_COLON);
                default: stamp_chars.push_back(any_space());
            endcase
        end
    endfunction

    task automatic send_item(input logic [7:0] c, input logic present, input logic is_last);
        @(negedge aclk);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_ch <= c;
        s_char_present <= present;
        s_last <= is_last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (present || is_last) begin
            chars_sent++;
        end
    endtask

    // The text ends either on its last character or on an empty end item;
    // empty items without last are sprinkled in between.
    task automatic send_stamp(input bit end_marker);
        int n;
        n = stamp_chars.size();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 24) == 0) begin
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            send_item(stamp_chars[i], 1'b1, !end_marker && i == n - 1);
        end
        if (end_marker || n == 0) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
        stamp_chars.delete();
    endtask

    task automatic send_text(input string txt, input bit end_marker);
        put_str(txt);
        send_stamp(end_marker);
    endtask

    // Result side: short random stalls, and one long hold-off on request.
    initial begin : result_sink
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge aclk);
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        bit hold_done;
        bit pause_done;
        hold_done = 1'b0;
        pause_done = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_ch = '0;
        s_char_present = 1'b0;
        s_last = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_text("1970-01-01 00:00:00", 1'b0);
        send_text("2000-02-29 23:59:59", 1'b1);
        send_text("-0001-12-31 12:00:00", 1'b0);
        // Every whitespace code, a plus sign and a run of blanks as separator.
        stamp_chars.push_back(CH_SPACE);
        stamp_chars.push_back(CH_TAB);
        put_str("+2024-3-5");
        stamp_chars.push_back(CH_CR);
        stamp_chars.push_back(CH_LF);
        stamp_chars.push_back(CH_VT);
        stamp_chars.push_back(CH_FF);
        put_str("7:8:9");
        send_stamp(1'b0);
        send_text("999999999-12-31 999999999:999999999:999999999", 1'b0);
        send_text("-999999999-01-01 -999999999:-999999999:-999999999", 1'b1);
        send_text("000002021-06-15 08:30:00", 1'b0);
        send_text("1234567890-01-01", 1'b0);
        send_text("2021-0000000001-01", 1'b0);
        send_text("2021-13-01", 1'b0);
        send_text("2021-00-10", 1'b0);
        send_text("2021-02-00", 1'b0);
        send_text("2021-02-32", 1'b0);
        send_text("2021-02-31 01:00:00", 1'b0);
        send_text("2024-12-31", 1'b0);
        send_text("2021-05", 1'b0);
        send_text("2021-05-+", 1'b0);
        send_text("2021-+-05", 1'b0);
        // A NUL right after the day ends the parsing with the time left at zero.
        put_str("2021-05-06");
        stamp_chars.push_back(CH_NUL);
        put_str(" 01:02:03");
        send_stamp(1'b0);
        put_str("2021-05-06 01:02:03xyz");
        stamp_chars.push_back(CH_TOP);
        send_stamp(1'b0);
        send_text("2021/05/06", 1'b0);
        send_text("2021-05-06 10", 1'b1);
        send_stamp(1'b1);
        send_text("2021-05-06 10:", 1'b0);
        send_text("2021 -05-06", 1'b0);

        while (chars_sent < ITEM_TARGET) begin
            if (chars_sent > CALM_AFTER) begin
                gaps_on = 1'b0;
            end
            if (!hold_done && chars_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_off_req = 1'b1;
            end
            if (!pause_done && chars_sent >= PAUSE_AT) begin
                pause_done = 1'b1;
                // Drop valid so the last item is not taken twice while waiting.
                @(negedge aclk);
                s_valid <= 1'b0;
                while (pending_stamps != 0) @(posedge aclk);
            end
            if ($urandom_range(0, 6) == 0) begin
                build_noise_stamp();
            end else begin
                build_random_stamp();
            end
            send_stamp($urandom_range(0, 3) == 0);
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (pending_stamps != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
